// ===== design/bmn_pkg.sv =====
// Shared constants, widths and sideband types of the Gaussian noise adder.
package bmn_pkg;

    localparam int UNIFORM_BITS = 24;
    localparam int UW           = UNIFORM_BITS + 1;
    localparam int PUW          = $clog2(UW);
    localparam int IPW          = $clog2(UNIFORM_BITS + 1);
    localparam int S_DATA_W     = ((32 + 2 * UW + 7) / 8) * 8;

    localparam int LOG_N  = 30;
    localparam int SQRT_N = 30;
    localparam int TERM_N = 4;
    localparam int PIPE_N = 1 + LOG_N + 1 + SQRT_N + 2 + 3 * TERM_N + 3;

    localparam int CFG_AW = 3;
    localparam logic REG_NOISE_RMS = 1'b0;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    typedef logic [6:0] div_t;

    localparam div_t COS_DIV [TERM_N] = '{7'd56, 7'd30, 7'd12, 7'd2};
    localparam div_t SIN_DIV [TERM_N] = '{7'd72, 7'd42, 7'd20, 7'd6};

    localparam logic [31:0] COS_RECIP [TERM_N] = '{
        32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
        32'((64'd1 << 32) / 64'd12), 32'((64'd1 << 32) / 64'd2)};
    localparam logic [31:0] SIN_RECIP [TERM_N] = '{
        32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6)};

    typedef struct packed {
        logic signed [31:0] px;
        logic               last;
        logic [IPW-1:0]     ip;
        logic [29:0]        s;
        logic               use_sin;
        logic               neg;
    } side_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic               last;
        logic               neg;
        logic               use_sin;
        logic [29:0]        r;
        logic [29:0]        x;
    } trig_t;

endpackage

// ===== design/bmn_log_cell.sv =====
// One squaring step of the fractional base-2 logarithm.
module bmn_log_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [30:0] m_in,
    input  logic [29:0] f_in,
    output logic [30:0] m_out,
    output logic [29:0] f_out
);
    logic [61:0] sq;
    logic [31:0] t;
    logic [30:0] m_next;
    logic [29:0] f_next;
    logic [30:0] m_reg;
    logic [29:0] f_reg;

    // Squaring the mantissa doubles the log; an overflow past two gives a one bit.
    assign sq     = 62'(m_in) * 62'(m_in);
    assign t      = sq[61:30];
    assign m_next = t[31] ? t[31:1] : t[30:0];
    assign f_next = {f_in[28:0], t[31]};

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg <= m_next;
            f_reg <= f_next;
        end
    end

    assign m_out = m_reg;
    assign f_out = f_reg;
endmodule

// ===== design/bmn_sqrt_cell.sv =====
// One bit of a restoring integer square root.
module bmn_sqrt_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [59:0] v_in,
    input  logic [31:0] rem_in,
    input  logic [29:0] root_in,
    output logic [59:0] v_out,
    output logic [31:0] rem_out,
    output logic [29:0] root_out
);
    logic [33:0] rem2;
    logic [33:0] trial;
    logic        ge;
    logic [59:0] v_reg;
    logic [31:0] rem_reg;
    logic [29:0] root_reg;
    logic [31:0] rem_next;
    logic [29:0] root_next;

    assign rem2      = {rem_in, v_in[59:58]};
    assign trial     = {2'b00, root_in, 2'b01};
    assign ge        = (rem2 >= trial);
    assign rem_next  = ge ? 32'(rem2 - trial) : 32'(rem2);
    assign root_next = {root_in[28:0], ge};

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg    <= {v_in[57:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ===== design/bmn_horner_cell.sv =====
// One Horner step a' = 1 - (x2 * a) / d of the cosine and sine series.
module bmn_horner_cell (
    input  logic                aclk,
    input  logic                en,
    input  logic [29:0]         x2_in,
    input  logic [30:0]         a_in,
    input  bmn_pkg::div_t       div,
    input  logic [31:0]         recip,
    output logic [29:0]         x2_out,
    output logic [30:0]         a_out
);
    import bmn_pkg::*;

    logic [60:0] prod1;
    logic [61:0] prod2;
    logic [36:0] qd;
    logic [36:0] rem;
    logic [29:0] q;
    logic [29:0] p_reg;
    logic [29:0] x2_s1_reg;
    logic [29:0] q0_reg;
    logic [29:0] p2_reg;
    logic [29:0] x2_s2_reg;
    logic [30:0] a_reg;
    logic [29:0] x2_s3_reg;
    logic [30:0] a_next;

    assign prod1 = 61'(x2_in) * 61'(a_in);
    assign prod2 = 62'(p_reg) * 62'(recip);

    // The reciprocal estimate is low by at most one; one compare corrects it.
    assign qd     = 37'(q0_reg) * 37'(div);
    assign rem    = 37'(p2_reg) - qd;
    assign q      = (rem >= 37'(div)) ? 30'(q0_reg + 30'd1) : q0_reg;
    assign a_next = ONE_Q30 - 31'(q);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= 30'(prod1 >> 30);
            x2_s1_reg <= x2_in;
            q0_reg    <= 30'(prod2 >> 32);
            p2_reg    <= p_reg;
            x2_s2_reg <= x2_s1_reg;
            a_reg     <= a_next;
            x2_s3_reg <= x2_s2_reg;
        end
    end

    assign x2_out = x2_s3_reg;
    assign a_out  = a_reg;
endmodule

// ===== design/box_muller_white_noise_adder_top.sv =====
// Box-Muller Gaussian noise adder: pipeline of log, square-root and series cells.
// Throughput: one request per cycle unless the skid entry is full; all cell rows advance together on en.
// The 79 stages are the 30 log cells, 30 root cells, 4 three-stage series cells and glue.
// Reset (aresetn low, synchronous) empties the pipeline and output buffer and clears noise_rms.
module box_muller_white_noise_adder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata from bit 0: pixel_in[31:0], uniform_a[24:0], uniform_b[24:0], zero fill.
    input  logic [bmn_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata from bit 0: pixel_out[31:0].
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmn_pkg::CFG_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bmn_pkg::*;

    // Configuration register. The user must write it only while the pipeline is empty; the block does not enforce this.
    logic [31:0] rms_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NOISE_RMS) ? rms_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rms_reg <= 32'd0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NOISE_RMS)) begin
            rms_reg <= pwdata;
        end
    end

    // The whole cell row moves when the output skid register is free, so a new
    // request is taken even while a finished result waits in the output register.
    logic              en;
    logic              acc;
    logic [PIPE_N-1:0] vld_reg;
    logic              sv_reg;
    logic              ov_reg;

    assign en       = !sv_reg;
    assign s_tready = en;
    assign acc      = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_N-2:0], acc};
        end
    end

    // Front stage: clamp u1, normalize it to a mantissa in [1,2) and reduce the
    // cosine phase to one octant with a quadrant sign.
    logic [UW-1:0]    ua;
    logic [UW-1:0]    ub;
    logic [UW-1:0]    u1c;
    logic [PUW-1:0]   pu;
    logic [UW+29:0]   mwide;
    logic [31:0]      phase;
    logic [29:0]      rfrac;
    side_t            f_side_next;
    side_t            f_side_reg;
    logic [30:0]      f_m_reg;

    assign ua = s_tdata[32 +: UW];
    assign ub = s_tdata[32 + UW +: UW];

    always_comb begin
        if (ua == '0) begin
            u1c = UW'(1);
        end else if (ua > (UW'(1) << UNIFORM_BITS)) begin
            u1c = UW'(1) << UNIFORM_BITS;
        end else begin
            u1c = ua;
        end
    end

    always_comb begin
        pu = '0;
        for (int i = 0; i < UW; i++) begin
            if (u1c[i]) begin
                pu = PUW'(i);
            end
        end
    end

    assign mwide = {u1c, 30'd0} >> pu;
    assign phase = 32'(64'(ub) << (32 - UNIFORM_BITS));
    assign rfrac = phase[29:0];

    always_comb begin
        f_side_next.px      = s_tdata[31:0];
        f_side_next.last    = s_tlast;
        f_side_next.ip      = IPW'(UNIFORM_BITS) - IPW'(pu);
        f_side_next.s       = rfrac[29] ? 30'(31'h4000_0000 - 31'(rfrac)) : rfrac;
        f_side_next.use_sin = rfrac[29] ^ phase[30];
        f_side_next.neg     = phase[31] ^ phase[30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= f_side_next;
            f_m_reg    <= mwide[30:0];
        end
    end

    // Log chain: each cell squares the mantissa and yields one fraction bit.
    logic [30:0] lg_m [LOG_N+1];
    logic [29:0] lg_f [LOG_N+1];
    side_t       lg_side_reg [LOG_N];

    assign lg_m[0] = f_m_reg;
    assign lg_f[0] = 30'd0;

    for (genvar k = 0; k < LOG_N; k++) begin : g_log
        bmn_log_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .m_in  (lg_m[k]),
            .f_in  (lg_f[k]),
            .m_out (lg_m[k+1]),
            .f_out (lg_f[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lg_side_reg[0] <= f_side_reg;
            for (int k = 1; k < LOG_N; k++) begin
                lg_side_reg[k] <= lg_side_reg[k-1];
            end
        end
    end

    // -log2(u1) in Q5.30, then -2 ln(u1) in Q6.26.
    logic [IPW+29:0] t_val;
    logic [IPW+58:0] l_prod;
    logic [31:0]     l_reg;
    side_t           l_side_reg;

    assign t_val  = {lg_side_reg[LOG_N-1].ip, 30'd0} - (IPW+30)'(lg_f[LOG_N]);
    assign l_prod = (IPW+59)'(t_val) * (IPW+59)'(TWO_LN2_Q28);

    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg      <= 32'(l_prod >> 32);
            l_side_reg <= lg_side_reg[LOG_N-1];
        end
    end

    // Square-root chain: one root bit per cell.
    logic [59:0] sq_v    [SQRT_N+1];
    logic [31:0] sq_rem  [SQRT_N+1];
    logic [29:0] sq_root [SQRT_N+1];
    side_t       sq_side_reg [SQRT_N];

    assign sq_v[0]    = {2'b00, l_reg, 26'd0};
    assign sq_rem[0]  = 32'd0;
    assign sq_root[0] = 30'd0;

    for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
        bmn_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .v_in     (sq_v[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .v_out    (sq_v[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= l_side_reg;
            for (int k = 1; k < SQRT_N; k++) begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // Octant angle in radians, then its square.
    side_t       sq_last;
    logic [60:0] x_prod;
    trig_t       x_tr_reg;
    logic [59:0] x2_prod;
    logic [29:0] x2_reg;
    trig_t       tr2_reg;

    assign sq_last = sq_side_reg[SQRT_N-1];
    assign x_prod  = 61'(sq_last.s) * 61'(HALF_PI_Q30);
    assign x2_prod = 60'(x_tr_reg.x) * 60'(x_tr_reg.x);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_tr_reg.px      <= sq_last.px;
            x_tr_reg.last    <= sq_last.last;
            x_tr_reg.neg     <= sq_last.neg;
            x_tr_reg.use_sin <= sq_last.use_sin;
            x_tr_reg.r       <= sq_root[SQRT_N];
            x_tr_reg.x       <= 30'(x_prod >> 30);
            x2_reg           <= 30'(x2_prod >> 30);
            tr2_reg          <= x_tr_reg;
        end
    end

    // Cosine and sine series run side by side; the octant picks one afterwards.
    logic [29:0] cx2 [TERM_N+1];
    logic [30:0] ca  [TERM_N+1];
    logic [29:0] sx2 [TERM_N+1];
    logic [30:0] sa  [TERM_N+1];
    trig_t       tr_dl_reg [3*TERM_N];

    assign cx2[0] = x2_reg;
    assign ca[0]  = ONE_Q30;
    assign sx2[0] = x2_reg;
    assign sa[0]  = ONE_Q30;

    for (genvar k = 0; k < TERM_N; k++) begin : g_term
        bmn_horner_cell u_cos (
            .aclk   (aclk),
            .en     (en),
            .x2_in  (cx2[k]),
            .a_in   (ca[k]),
            .div    (COS_DIV[k]),
            .recip  (COS_RECIP[k]),
            .x2_out (cx2[k+1]),
            .a_out  (ca[k+1])
        );
        bmn_horner_cell u_sin (
            .aclk   (aclk),
            .en     (en),
            .x2_in  (sx2[k]),
            .a_in   (sa[k]),
            .div    (SIN_DIV[k]),
            .recip  (SIN_RECIP[k]),
            .x2_out (sx2[k+1]),
            .a_out  (sa[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tr_dl_reg[0] <= tr2_reg;
            for (int k = 1; k < 3 * TERM_N; k++) begin
                tr_dl_reg[k] <= tr_dl_reg[k-1];
            end
        end
    end

    // |cos| of the full angle, then the Gaussian magnitude and the scaled noise.
    trig_t       tr_end;
    logic [60:0] s_prod;
    logic [30:0] v_reg;
    trig_t       v_tr_reg;
    logic [60:0] g_prod;
    logic [29:0] g_reg;
    logic signed [31:0] g_px_reg;
    logic        g_last_reg;
    logic        g_neg_reg;
    logic [61:0] n_prod;
    logic [35:0] n_reg;
    logic signed [31:0] n_px_reg;
    logic        n_last_reg;
    logic        n_neg_reg;

    assign tr_end = tr_dl_reg[3*TERM_N-1];
    assign s_prod = 61'(tr_end.x) * 61'(sa[TERM_N]);
    assign g_prod = 61'(v_tr_reg.r) * 61'(v_reg);
    assign n_prod = 62'(g_reg) * 62'(rms_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg      <= tr_end.use_sin ? 31'(s_prod >> 30) : ca[TERM_N];
            v_tr_reg   <= tr_end;
            g_reg      <= 30'(g_prod >> 30);
            g_px_reg   <= v_tr_reg.px;
            g_last_reg <= v_tr_reg.last;
            g_neg_reg  <= v_tr_reg.neg;
            n_reg      <= 36'(n_prod >> 26);
            n_px_reg   <= g_px_reg;
            n_last_reg <= g_last_reg;
            n_neg_reg  <= g_neg_reg;
        end
    end

    // Signed add with saturation to the pixel range.
    logic signed [37:0] pxe;
    logic signed [37:0] ne;
    logic signed [37:0] sum;
    logic [31:0]        sat;
    logic               push;
    logic               pop;

    assign pxe = {{6{n_px_reg[31]}}, n_px_reg};
    assign ne  = {2'b00, n_reg};
    assign sum = n_neg_reg ? (pxe - ne) : (pxe + ne);

    always_comb begin
        priority if (sum > 38'sd2147483647) begin
            sat = 32'h7FFF_FFFF;
        end else if (sum < -38'sd2147483648) begin
            sat = 32'h8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    // Output register with one skid entry behind it.
    logic [31:0] out_data_reg;
    logic        out_last_reg;
    logic [31:0] skid_data_reg;
    logic        skid_last_reg;

    assign push = vld_reg[PIPE_N-1] && en;
    assign pop  = ov_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else if (sv_reg) begin
            if (pop) begin
                sv_reg <= 1'b0;
            end
        end else if (push) begin
            if (!ov_reg || pop) begin
                ov_reg <= 1'b1;
            end else begin
                sv_reg <= 1'b1;
            end
        end else if (pop) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sv_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (push) begin
            if (!ov_reg || pop) begin
                out_data_reg <= sat;
                out_last_reg <= n_last_reg;
            end else begin
                skid_data_reg <= sat;
                skid_last_reg <= n_last_reg;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg |-> ov_reg)
        else $error("skid entry holds a result while the output register is empty");

    // A result leaving the last cell always lands in the output buffer.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[PIPE_N-1] && en) |=> ov_reg)
        else $error("result from the cell row was dropped");

    // The skid entry fills only when a held result was not taken.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sv_reg) |-> $past(ov_reg && !m_tready))
        else $error("skid entry filled while the output was draining");
`endif
endmodule
